/* rtl/core/curve_code_threshold_match_macros.svh */
// Assertion helpers for the file that checks its own logic.
`ifndef CURVE_CODE_THRESHOLD_MATCH_MACROS_SVH
`define CURVE_CODE_THRESHOLD_MATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCTM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/core/cctm_pkg.sv */
`timescale 1ns / 1ps

package cctm_pkg;

   localparam int DICT_CODES  = 32;
   localparam int CODE_POINTS = 16;
   localparam int COORD_BITS  = 16;

   localparam int CODE_BITS   = $clog2(DICT_CODES);
   localparam int POINT_BITS  = $clog2(CODE_POINTS);
   localparam int CCNT_BITS   = $clog2(DICT_CODES + 1);
   localparam int PCNT_BITS   = $clog2(CODE_POINTS + 1);
   localparam int STORE_DEPTH = DICT_CODES * CODE_POINTS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int ENTRY_BITS  = 2 * COORD_BITS;
   localparam int ERR_BITS    = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_MAX_ERROR     = 2'd0;
   localparam logic [1:0] REG_POINTS_IN_USE = 2'd1;
   localparam logic [1:0] REG_CODES_IN_USE  = 2'd2;

endpackage

/* rtl/core/cctm_ram.sv */
`timescale 1ns / 1ps

module cctm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cctm_point_cmp.sv */
`timescale 1ns / 1ps

// Chebyshev test of one query point against one stored point: both
// coordinate distances must be strictly below the limit.
module cctm_point_cmp (
   input  logic signed [cctm_pkg::COORD_BITS-1:0] query_x,
   input  logic signed [cctm_pkg::COORD_BITS-1:0] query_y,
   input  logic signed [cctm_pkg::COORD_BITS-1:0] entry_x,
   input  logic signed [cctm_pkg::COORD_BITS-1:0] entry_y,
   input  logic        [cctm_pkg::ERR_BITS-1:0]   max_error,
   output logic                                   hit
);

   localparam int DW = cctm_pkg::COORD_BITS + 1;

   logic signed [DW-1:0] diff_x;
   logic signed [DW-1:0] diff_y;
   logic        [DW-1:0] abs_x;
   logic        [DW-1:0] abs_y;
   logic        [DW-1:0] limit;

   always_comb begin
      diff_x = DW'(query_x) - DW'(entry_x);
      diff_y = DW'(query_y) - DW'(entry_y);
      // The magnitude of a DW-bit difference fits DW unsigned bits.
      abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
      abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
      limit  = DW'(max_error);
      hit    = (abs_x < limit) && (abs_y < limit);
   end

endmodule

/* rtl/core/curve_code_threshold_match.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    operation, code_index, point_index, x, y
// rsp      out        rsp_valid/stall    match_index, match_valid, last
// csr      in         csr_write          csr_index, csr_data
//
// A load item leaves the block idle and does not stall the request channel.
// A query point holds off the next item from its acceptance on, while the
// single read port of the dictionary RAM and the one shared point comparator
// visit one code per cycle.
// The final point of a query then walks the survivor mask, which waits
// while the result side stalls.
// Reset is synchronous; the dictionary RAM is not cleared and must be
// loaded before it is queried. req_stall is high while a point is in work.
module curve_code_threshold_match (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_operation,
   input  logic        [cctm_pkg::CODE_BITS-1:0]   req_code_index,
   input  logic        [cctm_pkg::POINT_BITS-1:0]  req_point_index,
   input  logic signed [cctm_pkg::COORD_BITS-1:0]  req_x,
   input  logic signed [cctm_pkg::COORD_BITS-1:0]  req_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic        [cctm_pkg::CODE_BITS-1:0]   rsp_match_index,
   output logic                                    rsp_match_valid,
   output logic                                    rsp_last,
   input  logic                                    csr_write,
   input  logic        [1:0]                       csr_index,
   input  logic        [cctm_pkg::ERR_BITS-1:0]    csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   localparam int CB = cctm_pkg::CODE_BITS;
   localparam int PB = cctm_pkg::POINT_BITS;
   localparam int CC = cctm_pkg::CCNT_BITS;
   localparam int PC = cctm_pkg::PCNT_BITS;
   localparam int NC = cctm_pkg::DICT_CODES;
   localparam int XW = cctm_pkg::COORD_BITS;

   state_type state_ff;

   logic [cctm_pkg::ERR_BITS-1:0] max_error_ff;
   logic [PC-1:0]                 points_in_use_ff;
   logic [CC-1:0]                 codes_in_use_ff;

   logic signed [XW-1:0] query_x_ff;
   logic signed [XW-1:0] query_y_ff;
   logic [PB-1:0]        point_ff;
   logic                 last_point_ff;
   logic [CC-1:0]        code_ff;
   logic                 rd_pend_ff;
   logic [CB-1:0]        rd_code_ff;
   logic [NC-1:0]        hits_ff;
   logic [NC-1:0]        mask_ff;
   logic [NC-1:0]        work_ff;
   logic [CB-1:0]        emit_idx_ff;

   logic          rsp_valid_ff;
   logic [CB-1:0] rsp_index_ff;
   logic          rsp_match_ff;
   logic          rsp_last_ff;

   logic [PC-1:0] points_eff;
   logic [CC-1:0] codes_eff;
   logic          req_accept;
   logic          point_in_range;
   logic          issue;
   logic          scan_done;
   logic          out_free;
   logic          emit_now;
   logic          hit;
   logic [NC-1:0] mask_in;

   logic [cctm_pkg::ADDR_BITS-1:0]  wr_addr;
   logic [cctm_pkg::ADDR_BITS-1:0]  rd_addr;
   logic [cctm_pkg::ENTRY_BITS-1:0] rd_data;

   always_comb begin
      if (points_in_use_ff == '0) begin
         points_eff = PC'(1);
      end else if (points_in_use_ff > PC'(cctm_pkg::CODE_POINTS)) begin
         points_eff = PC'(cctm_pkg::CODE_POINTS);
      end else begin
         points_eff = points_in_use_ff;
      end
      if (codes_in_use_ff == '0) begin
         codes_eff = CC'(1);
      end else if (codes_in_use_ff > CC'(NC)) begin
         codes_eff = CC'(NC);
      end else begin
         codes_eff = codes_in_use_ff;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign point_in_range = PC'(req_point_index) < points_eff;
   assign issue          = (state_ff == ST_SCAN) && (code_ff < codes_eff);
   // The last compare has landed in hits_ff once nothing is in flight.
   assign scan_done      = (state_ff == ST_SCAN) && !issue && !rd_pend_ff;
   assign mask_in        = mask_ff & hits_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign emit_now       = (state_ff == ST_EMIT) && out_free &&
                           (work_ff[0] || (work_ff == '0));

   assign wr_addr = {req_code_index, req_point_index};
   assign rd_addr = {code_ff[CB-1:0], point_ff};

   cctm_ram #(
      .WIDTH (cctm_pkg::ENTRY_BITS),
      .DEPTH (cctm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept && (req_operation == cctm_pkg::OP_LOAD)),
      .wr_addr (wr_addr),
      .wr_data ({req_y, req_x}),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cctm_point_cmp u_cmp (
      .query_x   (query_x_ff),
      .query_y   (query_y_ff),
      .entry_x   (rd_data[XW-1:0]),
      .entry_y   (rd_data[2*XW-1:XW]),
      .max_error (max_error_ff),
      .hit       (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         max_error_ff     <= cctm_pkg::ERR_BITS'(16);
         points_in_use_ff <= PC'(16);
         codes_in_use_ff  <= CC'(32);
         mask_ff          <= '1;
         rd_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               cctm_pkg::REG_MAX_ERROR:     max_error_ff     <= csr_data;
               cctm_pkg::REG_POINTS_IN_USE: points_in_use_ff <= csr_data[PC-1:0];
               cctm_pkg::REG_CODES_IN_USE:  codes_in_use_ff  <= csr_data[CC-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end

         rd_pend_ff <= issue;
         rd_code_ff <= code_ff[CB-1:0];
         if (rd_pend_ff) begin
            hits_ff[rd_code_ff] <= hit;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_operation == cctm_pkg::OP_QUERY) &&
                   point_in_range) begin
                  query_x_ff    <= req_x;
                  query_y_ff    <= req_y;
                  point_ff      <= req_point_index;
                  last_point_ff <= (PC'(req_point_index) == points_eff - PC'(1));
                  code_ff       <= '0;
                  hits_ff       <= '0;
                  if (req_point_index == '0) begin
                     mask_ff <= '1;
                  end
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  code_ff <= code_ff + CC'(1);
               end
               if (scan_done) begin
                  if (last_point_ff) begin
                     work_ff     <= mask_in;
                     emit_idx_ff <= '0;
                     mask_ff     <= '1;
                     state_ff    <= ST_EMIT;
                  end else begin
                     mask_ff  <= mask_in;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  if (work_ff[0]) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_index_ff <= emit_idx_ff;
                     rsp_match_ff <= 1'b1;
                     rsp_last_ff  <= ~|work_ff[NC-1:1];
                     if (~|work_ff[NC-1:1]) begin
                        state_ff <= ST_IDLE;
                     end
                  end else if (work_ff == '0) begin
                     // Nothing survived: one invalid item closes the query.
                     rsp_valid_ff <= 1'b1;
                     rsp_index_ff <= '0;
                     rsp_match_ff <= 1'b0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  work_ff     <= work_ff >> 1;
                  emit_idx_ff <= emit_idx_ff + CB'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_valid = rsp_match_ff;
   assign rsp_last        = rsp_last_ff;

`include "curve_code_threshold_match_macros.svh"

   `CCTM_ASSERT_SAME(a_read_in_range, clock, reset, rd_pend_ff, CC'(rd_code_ff) < codes_eff)
   `CCTM_ASSERT_SAME(a_miss_is_last, clock, reset, rsp_valid && !rsp_match_valid, rsp_last)
   `CCTM_ASSERT_NEXT(a_inner_point_idle, clock, reset, scan_done && !last_point_ff, state_ff == ST_IDLE)

endmodule
